@@ rtl/itno_pkg.sv @@
// ----------------------------------------------------------------------------
// itno_pkg
// Shared types and constants for the sorted interval table with wait query.
// ----------------------------------------------------------------------------
package itno_pkg;

  localparam int CAPACITY = 1024;
  localparam int TIME_W   = 30;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 2 * TIME_W;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [2:0] STAT_CLEARED  = 3'd0;
  localparam logic [2:0] STAT_INSERTED = 3'd1;
  localparam logic [2:0] STAT_DROPPED  = 3'd2;
  localparam logic [2:0] STAT_ANSWERED = 3'd3;
  localparam logic [2:0] STAT_FOREVER  = 3'd4;
  localparam logic [2:0] STAT_EMPTY    = 3'd5;

  typedef struct packed {
    logic [1:0]        func;
    logic [TIME_W-1:0] open_start;
    logic [TIME_W-1:0] open_end;
    logic [TIME_W-1:0] arrival_time;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [TIME_W-1:0] wait_time;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_LAST,
    ST_Q_ISSUE,
    ST_Q_CMP,
    ST_Q_END,
    ST_Q_NEXT,
    ST_DONE
  } state_t;

endpackage

@@ rtl/itno_ram.sv @@
// ----------------------------------------------------------------------------
// itno_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module itno_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/interval_table_next_open_wait.sv @@
// ----------------------------------------------------------------------------
// interval_table_next_open_wait
// Sorted interval table: clear, sorted insert, and next-opening wait query.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one command: clear, insert an interval
//   [open_start, open_end), or query an arrival_time. Each clear, insert or
//   query gives one result on out_valid/out_ready/out_data; func code 3 is
//   taken and dropped with no result.
//   Intervals live in one entry memory (start and end side by side) with a
//   registered read; one command is in work at a time.
//   Steps from input transfer to result valid:
//     clear, full or empty-table cases: straight to ST_DONE, then the output register.
//     insert: ST_INS_SCAN shifts up each stored entry greater than the new
//       one (one memory read and one write-back per cycle), then writes it.
//     query: at most ceil(log2(count + 1)) binary-search steps, each a memory
//       read (ST_Q_ISSUE) and a compare (ST_Q_CMP), then ST_Q_END and/or ST_Q_NEXT.
//   The result sits in an output register, so a new command is taken while
//   the previous result waits; a stalled receiver holds the block only once
//   the next result is ready. Reset empties the table at once; no clearing
//   pass runs.
// ----------------------------------------------------------------------------
module interval_table_next_open_wait (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  itno_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output itno_pkg::out_t out_data
);
  import itno_pkg::*;

  state_t              state_r, state_nxt;
  in_t                 item_r, item_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hi_r, hi_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  out_t                res_r, res_nxt;
  out_t                out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [TIME_W-1:0]   rd_start;
  logic [TIME_W-1:0]   rd_end;
  logic [CNT_W-1:0]    mid;
  logic                greater;

  itno_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_start = ram_rdata[ENTRY_W-1:TIME_W];
  assign rd_end   = ram_rdata[TIME_W-1:0];
  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign greater  = (rd_start > item_r.open_start) ||
                    ((rd_start == item_r.open_start) && (rd_end > item_r.open_end));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    addr_r <= addr_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    addr_nxt      = addr_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = (state_r == ST_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = addr_r + ADDR_W'(1);
    ram_wdata     = {item_r.open_start, item_r.open_end};
    ram_raddr     = addr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt  = '0;
          case (in_data.func)
            FUNC_CLEAR: begin
              cnt_nxt        = '0;
              res_nxt.status = STAT_CLEARED;
              state_nxt      = ST_DONE;
            end
            FUNC_INSERT: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                res_nxt.status = STAT_DROPPED;
                state_nxt      = ST_DONE;
              end else if (cnt_r == '0) begin
                ram_we         = 1'b1;
                ram_waddr      = '0;
                ram_wdata      = {in_data.open_start, in_data.open_end};
                cnt_nxt        = CNT_W'(1);
                res_nxt.status = STAT_INSERTED;
                state_nxt      = ST_DONE;
              end else begin
                ram_raddr = ADDR_W'(cnt_r - CNT_W'(1));
                addr_nxt  = ADDR_W'(cnt_r - CNT_W'(1));
                state_nxt = ST_INS_SCAN;
              end
            end
            FUNC_QUERY: begin
              if (cnt_r == '0) begin
                res_nxt.status = STAT_EMPTY;
                state_nxt      = ST_DONE;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = cnt_r;
                state_nxt = ST_Q_ISSUE;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_INS_SCAN: begin
        ram_we = 1'b1;
        if (greater) begin
          ram_wdata = ram_rdata;
          if (addr_r == '0) begin
            state_nxt = ST_INS_LAST;
          end else begin
            ram_raddr = addr_r - ADDR_W'(1);
            addr_nxt  = addr_r - ADDR_W'(1);
          end
        end else begin
          cnt_nxt        = cnt_r + CNT_W'(1);
          res_nxt.status = STAT_INSERTED;
          state_nxt      = ST_DONE;
        end
      end

      ST_INS_LAST: begin
        ram_we         = 1'b1;
        ram_waddr      = '0;
        cnt_nxt        = cnt_r + CNT_W'(1);
        res_nxt.status = STAT_INSERTED;
        state_nxt      = ST_DONE;
      end

      ST_Q_ISSUE: begin
        if (lo_r < hi_r) begin
          ram_raddr = ADDR_W'(mid);
          addr_nxt  = ADDR_W'(mid);
          state_nxt = ST_Q_CMP;
        end else if (lo_r != '0) begin
          ram_raddr = ADDR_W'(lo_r - CNT_W'(1));
          state_nxt = ST_Q_END;
        end else begin
          ram_raddr = ADDR_W'(lo_r);
          state_nxt = ST_Q_NEXT;
        end
      end

      ST_Q_CMP: begin
        if (rd_start < item_r.arrival_time) begin
          lo_nxt = CNT_W'(addr_r) + CNT_W'(1);
        end else begin
          hi_nxt = CNT_W'(addr_r);
        end
        state_nxt = ST_Q_ISSUE;
      end

      ST_Q_END: begin
        if (rd_end > item_r.arrival_time) begin
          res_nxt.status    = STAT_ANSWERED;
          res_nxt.wait_time = '0;
          state_nxt         = ST_DONE;
        end else if (lo_r < cnt_r) begin
          ram_raddr = ADDR_W'(lo_r);
          state_nxt = ST_Q_NEXT;
        end else begin
          res_nxt.status = STAT_FOREVER;
          state_nxt      = ST_DONE;
        end
      end

      ST_Q_NEXT: begin
        res_nxt.status    = STAT_ANSWERED;
        res_nxt.wait_time = rd_start - item_r.arrival_time;
        state_nxt         = ST_DONE;
      end

      ST_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE || state_r == ST_INS_SCAN || state_r == ST_INS_LAST))
    else $error("entry memory written outside insert");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Q_CMP) |-> (lo_r < hi_r && hi_r <= cnt_r))
    else $error("search window out of range");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside done state");

endmodule
